@@ rtl/core/ued_pkg.sv @@
// Shared types, constants and helpers for the backslash-u escape decoder.
package ued_pkg;

    localparam int unsigned CHAR_W      = 21;
    localparam int unsigned HELD_W      = 7;
    localparam int unsigned HOLD_DEPTH  = 5;
    localparam int unsigned CNT_W       = 3;
    localparam int unsigned CMD_Q_DEPTH = 4;

    localparam logic [CHAR_W-1:0] CH_BACKSLASH = 21'h00005C;
    localparam logic [CHAR_W-1:0] CH_LETTER_U  = 21'h000075;

    // Pending-prefix fill levels with a meaning of their own
    localparam logic [CNT_W-1:0] CNT_NONE = 3'd0;
    localparam logic [CNT_W-1:0] CNT_BS   = 3'd1;
    localparam logic [CNT_W-1:0] CNT_FULL = 3'd5;

    typedef struct packed {
        logic [CHAR_W-1:0] in_char;
        logic              in_end;
    } t_in_word;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              out_end;
    } t_out_word;

    // One command from front to back: emit held[0 .. flush_cnt-1], then tail if has_tail.
    typedef struct packed {
        logic [CNT_W-1:0]                 flush_cnt;
        logic [HOLD_DEPTH-1:0][HELD_W-1:0] held;
        logic                             has_tail;
        logic [CHAR_W-1:0]                tail;
        logic                             last;
    } t_cmd;

    // {valid, nibble}; the test looks at all 21 bits
    function automatic logic [4:0] hex_nib(input logic [CHAR_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 21'h30 && c <= 21'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 21'h41 && c <= 21'h46) || (c >= 21'h61 && c <= 21'h66)) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

endpackage

@@ rtl/core/ued_front.sv @@
// Front end: tracks the pending escape prefix and classifies each input word.
module ued_front import ued_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_word i_in,
    input  logic     i_q_full,
    output logic     o_cmd_push,
    output t_cmd     o_cmd
);

    logic [CNT_W-1:0]                  r_cnt, n_cnt;
    logic [HOLD_DEPTH-1:0][HELD_W-1:0] r_held, n_held;

    logic             accept;
    logic             is_bs, is_u, is_hex;
    logic             hold_now, done, brk, pass;
    logic [15:0]      code;
    logic [CNT_W-1:0] cnt_inc;
    logic [4:0]       nib_in, nib_2, nib_3, nib_4;

    assign accept  = i_push && !i_q_full;
    assign is_bs   = (i_in.in_char == CH_BACKSLASH);
    assign is_u    = (i_in.in_char == CH_LETTER_U);
    assign nib_in  = hex_nib(i_in.in_char);
    assign nib_2   = hex_nib(CHAR_W'(r_held[2]));
    assign nib_3   = hex_nib(CHAR_W'(r_held[3]));
    assign nib_4   = hex_nib(CHAR_W'(r_held[4]));
    assign is_hex  = nib_in[4];
    assign cnt_inc = r_cnt + 3'd1;

    assign code = {nib_2[3:0], nib_3[3:0], nib_4[3:0], nib_in[3:0]};

    always_comb begin
        hold_now = 1'b0;
        done     = 1'b0;
        brk      = 1'b0;
        pass     = 1'b0;
        priority if (r_cnt == CNT_NONE) begin
            hold_now = is_bs;
            pass     = !is_bs;
        end else if (r_cnt == CNT_BS) begin
            hold_now = is_u;
            brk      = !is_u;
        end else if (r_cnt == CNT_FULL) begin
            done = is_hex;
            brk  = !is_hex;
        end else begin
            hold_now = is_hex;
            brk      = !is_hex;
        end
    end

    always_comb begin
        n_held = r_held;
        if (hold_now) begin
            n_held[r_cnt] = i_in.in_char[HELD_W-1:0];
        end

        n_cnt = CNT_NONE;
        if (i_in.in_end) begin
            n_cnt = CNT_NONE;
        end else if (hold_now) begin
            n_cnt = cnt_inc;
        end else if (brk && is_bs) begin
            // breaking backslash starts over; slot 0 already holds a backslash
            n_cnt = CNT_BS;
        end
    end

    always_comb begin
        o_cmd.held      = n_held;
        o_cmd.last      = i_in.in_end;
        o_cmd.flush_cnt = CNT_NONE;
        if (brk) begin
            o_cmd.flush_cnt = r_cnt;
        end else if (i_in.in_end && hold_now) begin
            o_cmd.flush_cnt = cnt_inc;
        end
        o_cmd.has_tail = 1'b0;
        o_cmd.tail     = i_in.in_char;
        if (pass || (brk && !is_bs)) begin
            o_cmd.has_tail = 1'b1;
        end else if (done) begin
            o_cmd.has_tail = 1'b1;
            o_cmd.tail     = CHAR_W'(code);
        end else if (brk && is_bs && i_in.in_end) begin
            o_cmd.has_tail = 1'b1;
            o_cmd.tail     = CH_BACKSLASH;
        end
    end

    assign o_cmd_push = accept && (o_cmd.has_tail || (o_cmd.flush_cnt != CNT_NONE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNT_NONE;
        end else if (accept) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

endmodule

@@ rtl/core/ued_cmd_fifo.sv @@
// Command queue between front and back ends.
module ued_cmd_fifo import ued_pkg::*; #(
    parameter int unsigned DEPTH = CMD_Q_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_wdata,
    input  logic i_rd,
    output t_cmd o_rdata,
    output logic o_full,
    output logic o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_wr, do_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_rd) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/ued_back.sv @@
// Back end: walks each command one result word per cycle, while the output register is empty or popped, into it.
module ued_back import ued_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  logic      i_q_empty,
    output logic      o_q_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_word o_res
);

    logic [CNT_W-1:0] r_idx;
    logic             r_valid;
    t_out_word        r_res;

    logic             load, is_last;
    logic [CNT_W-1:0] last_idx;
    t_out_word        item;

    assign load     = !i_q_empty && (!r_valid || i_pop);
    assign last_idx = CNT_W'(i_cmd.flush_cnt + {2'b00, i_cmd.has_tail} - 3'd1);
    assign is_last  = (r_idx == last_idx);
    assign o_q_pop  = load && is_last;

    always_comb begin
        item.out_char = i_cmd.tail;
        if (r_idx < i_cmd.flush_cnt) begin
            item.out_char = CHAR_W'(i_cmd.held[r_idx]);
        end
        item.out_end = i_cmd.last && is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= is_last ? '0 : r_idx + 3'd1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= item;
        end
    end

    assign o_empty = !r_valid;
    assign o_res   = r_res;

endmodule

@@ rtl/core/unicode_escape_decoder.sv @@
// Backslash-u escape decoder, top level: front end, command queue, back end.
//
// Decodes a character stream one word per input: a backslash, the letter u and
// four ASCII hex digits (either case) collapse into one result holding the 16-bit
// code point; all else passes through unchanged. An unfinished prefix (up to five
// characters) is held and released as-is when the next character breaks it; a
// breaking backslash starts a new prefix. A word with in_end set flushes whatever
// is pending and the last result it causes carries out_end. The front end accepts
// one input word every cycle as long as the command queue (DEPTH entries) has room;
// o_full is that queue's full flag. Each input word yields 0 to 6 result words, and
// the back end emits one result word per cycle while o_res is taken or empty, out of
// a registered output stage. With the back end idle, an accepted input word's first
// result reaches o_res through the command queue and then the output register.
// There is no clearing pass after reset.
module unicode_escape_decoder import ued_pkg::*; #(
    parameter int unsigned DEPTH = CMD_Q_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    output logic      o_full,
    input  t_in_word  i_in,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_word o_res
);

    // front -> queue
    t_cmd cmd_wr;
    logic cmd_push;

    // queue -> back
    t_cmd cmd_rd;
    logic q_full, q_empty, q_pop;

    assign o_full = q_full;

    ued_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_wr)
    );

    ued_cmd_fifo #(
        .DEPTH (DEPTH)
    ) u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_push),
        .i_wdata (cmd_wr),
        .i_rd    (q_pop),
        .o_rdata (cmd_rd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back end drains the queue; one result word per cycle while the output is taken or empty
    ued_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd_rd),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_res     (o_res)
    );

endmodule

@@ rtl/core/ued_checker.sv @@
// Port-level checks for the escape decoder, bound to the top level.
module ued_checker import ued_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_push,
    input logic      o_full,
    input t_in_word  i_in,
    input logic      i_pop,
    input logic      o_empty,
    input t_out_word o_res
);

    logic in_acc;
    assign in_acc = i_push && !o_full;

    // reset leaves nothing to deliver and room to accept
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queue not clear after reset");

    // a waiting result word holds until taken
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_res)))
        else $error("result word changed while stalled");

    // no results appear out of thin air
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty && !in_acc && !$past(in_acc)) |=> o_empty)
        else $error("result word without input");

    // end of string always flushes something out
    a_end_yields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.in_end) |=> ##1 !o_empty)
        else $error("end-of-string word produced no result");

endmodule

bind unicode_escape_decoder ued_checker u_ued_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_push  (i_push),
    .o_full  (o_full),
    .i_in    (i_in),
    .i_pop   (i_pop),
    .o_empty (o_empty),
    .o_res   (o_res)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the backslash-u escape decoder: directed and random strings.
module tb_top;
    import ued_pkg::*;

    // Tracks the pending escape prefix and predicts the unescaped words.
    class unescape_tracker;
        logic [HELD_W-1:0] prefix_buf [HOLD_DEPTH];
        int unsigned       prefix_len;
        t_out_word         unescaped_q [$];
        int unsigned       errors;

        function new();
            prefix_len = 0;
            errors     = 0;
        endfunction

        // Value of an ASCII hex digit, -1 otherwise. All 21 bits take part.
        function int hex_digit_value(logic [CHAR_W-1:0] c);
            if (c >= 21'h30 && c <= 21'h39) return int'(c - 21'h30);
            if (c >= 21'h41 && c <= 21'h46) return int'(c - 21'h41) + 10;
            if (c >= 21'h61 && c <= 21'h66) return int'(c - 21'h61) + 10;
            return -1;
        endfunction

        function void emit_char(logic [CHAR_W-1:0] c);
            t_out_word w;
            w.out_char = c;
            w.out_end  = 1'b0;
            unescaped_q = {unescaped_q, w};
        endfunction

        function void hold_char(logic [CHAR_W-1:0] c);
            if (prefix_len < HOLD_DEPTH) begin
                prefix_buf[prefix_len] = c[HELD_W-1:0];
                prefix_len++;
            end
        endfunction

        function void flush_prefix();
            for (int k = 0; k < prefix_len; k++) emit_char(CHAR_W'(prefix_buf[k]));
            prefix_len = 0;
        endfunction

        // Character seen with nothing pending: a backslash opens a prefix.
        function void start_fresh(logic [CHAR_W-1:0] c);
            if (c == CH_BACKSLASH) hold_char(c);
            else emit_char(c);
        endfunction

        // Called for every accepted input word.
        function void take_char(t_in_word w);
            logic [CHAR_W-1:0] c;
            logic [15:0]       code;
            int unsigned       first;
            t_out_word         tail;
            c     = w.in_char;
            first = unescaped_q.size();
            if (prefix_len == 0) begin
                start_fresh(c);
            end else if (prefix_len == 1) begin
                if (c == CH_LETTER_U) begin
                    hold_char(c);
                end else begin
                    flush_prefix();
                    start_fresh(c);
                end
            end else if (hex_digit_value(c) >= 0) begin
                if (prefix_len == HOLD_DEPTH) begin
                    code = '0;
                    for (int k = 2; k < HOLD_DEPTH; k++)
                        code = {code[11:0], 4'(hex_digit_value(CHAR_W'(prefix_buf[k])))};
                    code = {code[11:0], 4'(hex_digit_value(c))};
                    prefix_len = 0;
                    emit_char(CHAR_W'(code));
                end else begin
                    hold_char(c);
                end
            end else begin
                flush_prefix();
                start_fresh(c);
            end
            if (w.in_end) begin
                flush_prefix();
                if (unescaped_q.size() > first) begin
                    tail = unescaped_q[unescaped_q.size() - 1];
                    tail.out_end = 1'b1;
                    unescaped_q[unescaped_q.size() - 1] = tail;
                end
            end
        endfunction

        // Called for every accepted result word.
        function void match_word(t_out_word got);
            t_out_word want;
            if (unescaped_q.size() == 0) begin
                $display("%0t: unexpected word char=%h end=%b", $time, got.out_char,
                         got.out_end);
                errors++;
                return;
            end
            want = unescaped_q.pop_front();
            if (got.out_char !== want.out_char) begin
                $display("%0t: out_char expected %h actual %h", $time, want.out_char,
                         got.out_char);
                errors++;
            end
            if (got.out_end !== want.out_end) begin
                $display("%0t: out_end expected %b actual %b", $time, want.out_end,
                         got.out_end);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return unescaped_q.size();
        endfunction
    endclass

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_push  = 1'b0;
    logic      i_pop   = 1'b0;
    t_in_word  i_in    = '0;
    logic      o_full;
    logic      o_empty;
    t_out_word o_res;

    // Idle / stall odds in percent, changed per phase
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned sent         = 0;

    unescape_tracker tracker = new();

    unicode_escape_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .o_full  (o_full),
        .i_in    (i_in),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_res   (o_res)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or drops words.
    initial begin
        #2_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // Both handshakes sampled at the edge, before any NBA update lands.
    // Input side is noted first so an expectation is always in place.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_push && !o_full) tracker.take_char(i_in);
            if (i_pop && !o_empty) tracker.match_word(o_res);
        end
        i_pop <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    function automatic logic [CHAR_W-1:0] pick_hex_char();
        int unsigned r;
        r = $urandom_range(0, 21);
        if (r < 10) return CHAR_W'(21'h30 + r);
        if (r < 16) return CHAR_W'(21'h41 + r - 10);
        return CHAR_W'(21'h61 + r - 16);
    endfunction

    // Noise characters, which may still happen to be escape pieces: printable ASCII,
    // near misses around the hex ranges, backslash and u, hex-looking low bytes with upper
    // bits set, and the full code point range.
    function automatic logic [CHAR_W-1:0] pick_other_char();
        logic [7:0] lo;
        case ($urandom_range(0, 3))
            0: return CHAR_W'($urandom_range(21'h20, 21'h7E));
            1: begin
                case ($urandom_range(0, 8))
                    0: return 21'h2F;
                    1: return 21'h3A;
                    2: return 21'h40;
                    3: return 21'h47;
                    4: return 21'h60;
                    5: return 21'h67;
                    6: return 21'h74;
                    7: return 21'h15C;
                    default: return 21'h175;
                endcase
            end
            2: begin
                lo = 8'(pick_hex_char());
                return {13'($urandom_range(1, 13'h10FF)), lo};
            end
            default: return CHAR_W'($urandom_range(0, 21'h10FFFF));
        endcase
    endfunction

    // Push one word, with random idle cycles ahead of it.
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
        t_in_word w;
        w.in_char = c;
        w.in_end  = last;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_in   <= w;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        sent++;
    endtask

    // One string: mostly whole escapes, plus broken prefixes, stray
    // backslashes and noise. Final character carries the end flag.
    task automatic send_random_string();
        logic [CHAR_W-1:0] str_q [$];
        int unsigned       roll;
        repeat ($urandom_range(1, 8)) begin
            roll = $urandom_range(0, 99);
            if (roll < 35) begin
                str_q = {str_q, CH_BACKSLASH};
                str_q = {str_q, CH_LETTER_U};
                repeat (4) str_q = {str_q, pick_hex_char()};
            end else if (roll < 50) begin
                // prefix cut short at any length up to five held
                str_q = {str_q, CH_BACKSLASH};
                if ($urandom_range(0, 3) != 0) begin
                    str_q = {str_q, CH_LETTER_U};
                    repeat ($urandom_range(0, 3)) str_q = {str_q, pick_hex_char()};
                end
            end else if (roll < 58) begin
                str_q = {str_q, CH_BACKSLASH};
            end else if (roll < 68) begin
                str_q = {str_q, ($urandom_range(0, 1) ? CH_LETTER_U : pick_hex_char())};
            end else begin
                str_q = {str_q, pick_other_char()};
            end
        end
        foreach (str_q[k]) send_char(str_q[k], k == str_q.size() - 1);
    endtask

    initial begin
        int unsigned phase_start;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // plain words and field extremes
        send_char(21'h41, 1'b0);
        send_char(21'h0, 1'b0);
        send_char(21'h10FFFF, 1'b1);
        // whole escape, mixed-case digits
        send_char(CH_BACKSLASH, 1'b0);
        send_char(CH_LETTER_U, 1'b0);
        send_char(21'h30, 1'b0);
        send_char(21'h39, 1'b0);
        send_char(21'h61, 1'b0);
        send_char(21'h46, 1'b0);
        // low byte looks like a hex digit but the word is not one
        send_char(CH_BACKSLASH, 1'b0);
        send_char(CH_LETTER_U, 1'b0);
        send_char(21'h31, 1'b0);
        send_char(21'h130, 1'b0);
        // backslash breaks a prefix, then an escape closed by the last word
        send_char(CH_BACKSLASH, 1'b0);
        send_char(CH_LETTER_U, 1'b0);
        send_char(CH_BACKSLASH, 1'b0);
        send_char(CH_LETTER_U, 1'b0);
        send_char(21'h66, 1'b0);
        send_char(21'h41, 1'b0);
        send_char(21'h39, 1'b0);
        send_char(21'h30, 1'b1);
        // lone backslash flushed by the end flag
        send_char(CH_BACKSLASH, 1'b1);
        // beyond the code point range: passes through
        send_char(21'h1FFFFF, 1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 85;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 85;
                end
                default: begin
                    tx_idle_pct  = 18;
                    rx_stall_pct = 18;
                end
            endcase
            phase_start = sent;
            while (sent - phase_start < 50) send_random_string();
        end
        i_push <= 1'b0;

        // drain, then keep clocking to catch stray words
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/ued_pkg.sv
rtl/core/ued_front.sv
rtl/core/ued_cmd_fifo.sv
rtl/core/ued_back.sv
rtl/core/unicode_escape_decoder.sv
rtl/core/ued_checker.sv
tb/tb_top.sv
